>>> hdl/adm_pkg.sv
package adm_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int ROUNDS      = 14;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RUN,
        ST_EMIT0,
        ST_EMIT1
    } state_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_MARK,
        PH_LEN
    } phase_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

>>> hdl/adm_aes_core.sv
module adm_aes_core
    import adm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [255:0]   key,
    input  logic [127:0]   chain_in,
    output core_ctl_t      ctl,
    output logic [127:0]   state_out
);

    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [255:0] kw_reg, kw_next;
    logic [127:0] st_reg, st_next;
    logic [7:0]   rc_reg, rc_next;
    logic [7:0]   sb [0:15];
    logic [7:0]   sr [0:15];
    logic [7:0]   mc [0:15];
    logic [127:0] rnd;
    logic [127:0] rk_use;
    logic [127:0] nk;
    logic [31:0]  t0;
    logic [31:0]  w0, w1, w2, w3;
    logic [7:0]   a0, a1, a2, a3, al;

    // Round key window kw holds two round keys: lower half used now.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = sbox(st_reg[127 - 8 * i -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sr[c * 4 + r] = sb[((c + r) % 4) * 4 + r];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sr[c * 4];
            a1 = sr[c * 4 + 1];
            a2 = sr[c * 4 + 2];
            a3 = sr[c * 4 + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[c * 4]     = a0 ^ al ^ xtime(a0 ^ a1);
            mc[c * 4 + 1] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[c * 4 + 2] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[c * 4 + 3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++)
        begin
            rnd[127 - 8 * i -: 8] = (round_reg == 4'(ROUNDS)) ? sr[i] : mc[i];
        end
        rk_use = kw_reg[127:0];

        // Next 4 key words from previous 8.
        if (!round_reg[0])
        begin
            t0 = sub_word(kw_reg[31:0]);
        end
        else
        begin
            t0 = sub_word({kw_reg[23:0], kw_reg[31:24]}) ^ {rc_reg, 24'h0};
        end
        w0 = kw_reg[255:224] ^ t0;
        w1 = kw_reg[223:192] ^ w0;
        w2 = kw_reg[191:160] ^ w1;
        w3 = kw_reg[159:128] ^ w2;
        nk = {w0, w1, w2, w3};

        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        kw_next    = kw_reg;
        st_next    = st_reg;
        rc_next    = rc_reg;
        if (start && !busy_reg)
        begin
            busy_next  = 1'b1;
            round_next = 4'd1;
            st_next    = chain_in ^ key[255:128];
            kw_next    = {key[255:128], key[127:0]};
            rc_next    = 8'h01;
        end
        else if (busy_reg)
        begin
            st_next = rnd ^ rk_use;
            kw_next = {kw_reg[127:0], nk};
            if (!round_reg[0])
            begin
                rc_next = xtime(rc_reg);
            end
            if (round_reg == 4'(ROUNDS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                round_next = round_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            round_reg <= round_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kw_reg <= kw_next;
        st_reg <= st_next;
        rc_reg <= rc_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign state_out = st_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without busy");
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (round_reg >= 4'd1 && round_reg <= 4'(ROUNDS)))
        else $error("round out of range");
`endif

endmodule

>>> hdl/aes256_davies_meyer_digest_top.sv
// Davies-Meyer digest over AES-256, fed one message byte per beat on cmd=0; cmd=1
// finishes and emits two 64-bit digest beats (last_word on the second). The 32nd
// byte of a block starts one compression by the shared AES round unit (one round
// per cycle, key schedule on the fly). A finish passes through a padding state and
// two compressions before the first digest beat appears.
// The block accepts no beat while padding, compressing or emitting.
module aes256_davies_meyer_digest_top
    import adm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        last_word
);

    state_t       state_reg, state_next;
    phase_t       phase_reg, phase_next;
    logic [4:0]   fill_reg, fill_next;
    logic [63:0]  total_reg, total_next;
    logic [127:0] chain_reg, chain_next;
    logic [255:0] blk_reg, blk_next;
    logic         start;
    logic         accept;
    core_ctl_t    ctl;
    logic [127:0] enc;

    adm_aes_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .key       (blk_next),
        .chain_in  (chain_next),
        .ctl       (ctl),
        .state_out (enc)
    );

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT0) || (state_reg == ST_EMIT1);
    assign last_word   = (state_reg == ST_EMIT1);
    assign digest_word = last_word ? chain_reg[63:0] : chain_reg[127:64];

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        chain_next = chain_reg;
        blk_next   = blk_reg;
        start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!cmd)
                    begin
                        blk_next[255 - 8 * fill_reg -: 8] = data_byte;
                        fill_next  = fill_reg + 5'd1;
                        total_next = total_reg + 64'd1;
                        if (fill_reg == 5'(BLOCK_BYTES - 1))
                        begin
                            phase_next = PH_DATA;
                            state_next = ST_RUN;
                            start      = 1'b1;
                        end
                    end
                    else
                    begin
                        blk_next[255 - 8 * fill_reg -: 8] = PAD_BYTE;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                for (int i = 0; i < BLOCK_BYTES; i++)
                begin
                    if (5'(i) > fill_reg)
                    begin
                        blk_next[255 - 8 * i -: 8] = 8'h00;
                    end
                end
                phase_next = PH_MARK;
                state_next = ST_RUN;
                start      = 1'b1;
            end
            ST_RUN:
            begin
                if (ctl.done)
                begin
                    chain_next = chain_reg ^ enc;
                    case (phase_reg)
                        PH_MARK:
                        begin
                            blk_next[255:128] = {64'h0, total_reg};
                            phase_next = PH_LEN;
                            start      = 1'b1;
                        end
                        PH_LEN:
                        begin
                            state_next = ST_EMIT0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT0:
            begin
                if (!out_stall)
                begin
                    state_next = ST_EMIT1;
                end
            end
            ST_EMIT1:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                    chain_next = '0;
                    fill_next  = '0;
                    total_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
            fill_reg  <= '0;
            total_reg <= '0;
            chain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

`ifndef NO_ASSERTIONS
    a_start_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !ctl.busy)
        else $error("start while core busy");
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT1) |-> ($past(state_reg) == ST_EMIT0
            || $past(state_reg) == ST_EMIT1))
        else $error("second word out of order");
    a_run_core: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && $past(state_reg) == ST_RUN) |-> (ctl.busy || ctl.done))
        else $error("core idle during run");
`endif

endmodule
